>>> src/iirl_pkg.sv
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants of the indexed insert/remove list unit.
// ----------------------------------------------------------------------------
package iirl_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = 5;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 40;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_t;

    typedef struct packed {
        logic out_stall;
    } stat_t;

endpackage

>>> src/indexed_insert_remove_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_unit: ordered word list with indexed insert/remove
// The operand register takes an input beat, and the execute step then writes
// the result register. No new input beat is taken until execute has run; a
// result held by m_tready low stalls execute, then the input.
// Reset: count clears to zero, capacity limit to 16; entries are not cleared.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation[2:0], position[7:3], word_in[39:8]
    input  logic [iirl_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], word_out[33:2], entry_count[38:34], is_empty[39]
    output logic [iirl_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [iirl_pkg::CNT_W-1:0] cfg_data
);
    import iirl_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    iirl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    iirl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:34] <= 5'(DEPTH)))
        else $error("entry count beyond depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39] == (m_tdata[38:34] == 5'd0)))
        else $error("empty flag disagrees with count");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ST_DONE) |-> (m_tdata[33:2] == 32'd0))
        else $error("word out nonzero on failed operation");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken during execute");
`endif

endmodule

>>> src/iirl_ctrl.sv
// ----------------------------------------------------------------------------
// iirl_ctrl
// Controller: takes one beat into the operand register, then fires the
// execute step once the result register is free.
// ----------------------------------------------------------------------------
module iirl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  iirl_pkg::stat_t stat,
    output iirl_pkg::ctrl_t ctrl
);
    import iirl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.out_stall)
                begin
                    ctrl.exec  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/iirl_datapath.sv
// ----------------------------------------------------------------------------
// iirl_datapath
// Operand register, row of shifting entry cells, count and capacity
// registers, and the result register.
// ----------------------------------------------------------------------------
module iirl_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  iirl_pkg::ctrl_t                ctrl,
    output iirl_pkg::stat_t                stat,
    input  logic [iirl_pkg::IN_W-1:0]      s_tdata,
    input  logic                           cfg_we,
    input  logic [iirl_pkg::CNT_W-1:0]     cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iirl_pkg::OUT_W-1:0]     m_tdata
);
    import iirl_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    op_t                  op_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0] word_reg;

    logic [WORD_BITS-1:0] entries_reg [DEPTH];
    logic [WORD_BITS-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     cap_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    logic [31:0]          word_out_reg;
    logic [CNT_W-1:0]     count_out_reg;
    logic                 empty_reg;

    logic [CNT_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     pos_eff;
    status_t              status_next;
    logic [31:0]          rd_word;
    logic                 grow;
    logic                 shrink;
    logic                 wr_one;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg   <= op_t'(s_tdata[OP_W-1:0]);
            pos_reg  <= s_tdata[OP_W+CNT_W-1:OP_W];
            word_reg <= s_tdata[OP_W+CNT_W+WORD_BITS-1:OP_W+CNT_W];
        end
    end

    always_comb
    begin
        eff_cap     = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
        pos_eff     = (op_reg == OP_APPEND) ? count_reg : pos_reg;
        status_next = ST_DONE;
        rd_word     = '0;
        count_next  = count_reg;
        grow        = 1'b0;
        shrink      = 1'b0;
        wr_one      = 1'b0;
        unique case (op_reg)
            OP_APPEND, OP_INSERT:
            begin
                if (pos_eff > count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg >= eff_cap)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    grow       = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_word = 32'(entries_reg[pos_reg[IDX_W-1:0]]);
                end
            end
            OP_WRITE:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    wr_one = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_reg >= count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    shrink     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] I_C = CNT_W'(i);
        logic [WORD_BITS-1:0] up_word;
        logic [WORD_BITS-1:0] down_word;

        if (i == 0)
        begin : g_first
            assign up_word = entries_reg[i];
        end
        else
        begin : g_up
            assign up_word = entries_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign down_word = entries_reg[i];
        end
        else
        begin : g_down
            assign down_word = entries_reg[i+1];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (grow && I_C == pos_eff)
            begin
                entries_next[i] = word_reg;
            end
            else if (grow && I_C > pos_eff && I_C <= count_reg)
            begin
                entries_next[i] = up_word;
            end
            else if (wr_one && I_C == pos_reg)
            begin
                entries_next[i] = word_reg;
            end
            else if (shrink && I_C >= pos_reg && (I_C + CNT_W'(1)) < count_reg)
            begin
                entries_next[i] = down_word;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.exec)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg    <= status_next;
            word_out_reg  <= rd_word;
            count_out_reg <= count_next;
            empty_reg     <= (count_next == '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {empty_reg, count_out_reg, word_out_reg, status_reg};

endmodule

>>> tb/tb_indexed_insert_remove_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for indexed_insert_remove_list_unit
// Runs list operations through the input stream and checks every output beat
// against a cycle-free model of the list, or against the fixed result that a
// directed row gives. A short directed table covers empty and range errors,
// unused codes and clear. Random phases then vary the capacity limit: zero,
// one, saturated, and lowered below the live count. Both stream sides idle
// at random, and one long output hold-off backs up the input side.
module tb_indexed_insert_remove_list_unit;

    import iirl_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_ROWS        = 20;
    localparam int NUM_PHASES      = 7;

    typedef enum int { MIX_GROW = 0, MIX_EVEN = 1, MIX_SHRINK = 2 } mix_t;

    typedef struct packed {
        status_t              status;
        logic [WORD_BITS-1:0] word;
        logic [CNT_W-1:0]     count;
        logic                 empty;
    } list_result_t;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [4:0]           pos;
        logic [WORD_BITS-1:0] word;
        bit                   known;
        status_t              status;
        logic [WORD_BITS-1:0] rd;
        logic [CNT_W-1:0]     count;
    } step_row_t;

    typedef struct {
        logic [CNT_W-1:0] cap;
        int               items;
        mix_t             mix;
        bit               pressure;
        bit               quiet;
    } phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;

    logic [WORD_BITS-1:0] list_words [DEPTH];
    int                   list_count = 0;
    int                   capacity_reg = 16;
    list_result_t         expected_results [$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    bit                   hold_request = 1'b0;
    bit                   quiet = 1'b0;
    step_row_t            dir_rows [NUM_ROWS];
    phase_t               phases [NUM_PHASES];
    int                   op_weight [3][8];

    indexed_insert_remove_list_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** indexed_insert_remove_list_unit: FAILED **");
            $finish;
        end
    end

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [4:0] pos,
                                                   logic [WORD_BITS-1:0] word);
        list_result_t r;
        int           eff_cap;
        int           at;
        int           i;
        r.status = ST_DONE;
        r.word   = '0;
        eff_cap  = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        case (op)
            OP_APPEND, OP_INSERT:
            begin
                at = (op == OP_APPEND) ? list_count : int'(pos);
                if (at > list_count)
                    r.status = ST_RANGE;
                else if (list_count >= eff_cap)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_count; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = word;
                    list_count++;
                end
            end
            OP_READ:
            begin
                if (int'(pos) >= list_count)
                    r.status = ST_RANGE;
                else
                    r.word = list_words[pos];
            end
            OP_WRITE:
            begin
                if (int'(pos) >= list_count)
                    r.status = ST_RANGE;
                else
                    list_words[pos] = word;
            end
            OP_REMOVE:
            begin
                if (int'(pos) >= list_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                end
            end
            OP_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        r.count = CNT_W'(list_count);
        r.empty = (list_count == 0);
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic offer_item(logic [OP_W-1:0] op, logic [4:0] pos, logic [WORD_BITS-1:0] word,
                              bit known, list_result_t fixed);
        list_result_t pred;
        int           gap;
        s_tdata  <= {word, pos, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_list_op(op, pos, word);
        expected_results.push_back(known ? fixed : pred);
        gap = idle_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        capacity_reg = int'(value);
    endtask

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat", m_tdata, '0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", OUT_W'(m_tdata[1:0]), OUT_W'(want.status));
                if (m_tdata[33:2] !== want.word)
                    report_mismatch("word_out", OUT_W'(m_tdata[33:2]), OUT_W'(want.word));
                if (m_tdata[38:34] !== want.count)
                    report_mismatch("entry_count", OUT_W'(m_tdata[38:34]),
                                    OUT_W'(want.count));
                if (m_tdata[39] !== want.empty)
                    report_mismatch("is_empty", OUT_W'(m_tdata[39]), OUT_W'(want.empty));
            end
        end
    end

    initial
    begin : receiver
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        list_result_t     fixed;
        logic [OP_W-1:0]  op;
        logic [4:0]       pos;
        logic [WORD_BITS-1:0] word;
        int               r;
        int               acc;
        int               hi;
        int               code;

        op_weight[MIX_GROW]   = '{35, 10, 8, 35, 7, 2, 2, 1};
        op_weight[MIX_EVEN]   = '{18, 20, 15, 18, 20, 3, 3, 3};
        op_weight[MIX_SHRINK] = '{8, 15, 10, 8, 50, 3, 3, 3};

        dir_rows = '{
            '{OP_READ,   5'd0,  32'h0,        1'b1, ST_RANGE, 32'h0, 5'd0},
            '{OP_REMOVE, 5'd0,  32'h0,        1'b1, ST_RANGE, 32'h0, 5'd0},
            '{OP_WRITE,  5'd0,  32'hFFFFFFFF, 1'b1, ST_RANGE, 32'h0, 5'd0},
            '{OP_INSERT, 5'd1,  32'hFFFFFFFF, 1'b1, ST_RANGE, 32'h0, 5'd0},
            '{OP_INSERT, 5'd0,  32'hFFFFFFFF, 1'b1, ST_DONE,  32'h0, 5'd1},
            '{OP_APPEND, 5'd31, 32'h00000000, 1'b1, ST_DONE,  32'h0, 5'd2},
            '{OP_APPEND, 5'd0,  32'hA5A5A5A5, 1'b1, ST_DONE,  32'h0, 5'd3},
            '{OP_INSERT, 5'd1,  32'h12345678, 1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_READ,   5'd1,  32'h0,        1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_READ,   5'd3,  32'h0,        1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_WRITE,  5'd2,  32'h5A5A5A5A, 1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_REMOVE, 5'd0,  32'h0,        1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_READ,   5'd0,  32'h0,        1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_INSERT, 5'd3,  32'h80000001, 1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_READ,   5'd31, 32'h0,        1'b1, ST_RANGE, 32'h0, 5'd4},
            '{OP_SPARE6, 5'd0,  32'h0,        1'b1, ST_DONE,  32'h0, 5'd4},
            '{OP_SPARE7, 5'd31, 32'hFFFFFFFF, 1'b1, ST_DONE,  32'h0, 5'd4},
            '{OP_REMOVE, 5'd3,  32'h0,        1'b0, ST_DONE,  32'h0, 5'd0},
            '{OP_CLEAR,  5'd0,  32'h0,        1'b1, ST_DONE,  32'h0, 5'd0},
            '{OP_APPEND, 5'd0,  32'h80000001, 1'b1, ST_DONE,  32'h0, 5'd1}
        };

        phases = '{
            '{5'd1,  30,  MIX_GROW,   1'b0, 1'b0},
            '{5'd0,  20,  MIX_GROW,   1'b0, 1'b0},
            '{5'd16, 120, MIX_GROW,   1'b1, 1'b0},
            '{5'd3,  60,  MIX_EVEN,   1'b0, 1'b0},
            '{5'd31, 150, MIX_EVEN,   1'b0, 1'b1},
            '{5'd8,  100, MIX_SHRINK, 1'b0, 1'b0},
            '{5'd16, 250, MIX_EVEN,   1'b0, 1'b0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            fixed.status = dir_rows[k].status;
            fixed.word   = dir_rows[k].rd;
            fixed.count  = dir_rows[k].count;
            fixed.empty  = (dir_rows[k].count == 0);
            offer_item(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].word,
                       dir_rows[k].known, fixed);
        end

        fixed = '0;
        foreach (phases[p])
        begin
            write_capacity(phases[p].cap);
            quiet = phases[p].quiet;
            if (phases[p].pressure)
                hold_request = 1'b1;
            repeat (phases[p].items)
            begin
                r    = $urandom_range(0, 99);
                code = 0;
                acc  = op_weight[phases[p].mix][0];
                while (r >= acc)
                begin
                    code++;
                    acc += op_weight[phases[p].mix][code];
                end
                op = OP_W'(code);

                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    hi  = (op == OP_INSERT) ? list_count : (list_count > 0 ? list_count - 1 : 0);
                    pos = 5'($urandom_range(0, hi));
                end
                else if (r < 90)
                    pos = 5'(list_count + $urandom_range(0, 1));
                else
                    pos = 5'($urandom_range(0, 31));

                r = $urandom_range(0, 99);
                if (r < 10)
                    word = '0;
                else if (r < 20)
                    word = '1;
                else
                    word = $urandom;

                offer_item(op, pos, word, 1'b0, fixed);
            end
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** indexed_insert_remove_list_unit: PASSED **");
        else
            $display("** indexed_insert_remove_list_unit: FAILED **");
        $finish;
    end

endmodule
